>>> hdl/sfd_pkg.sv
package sfd_pkg;

  localparam int unsigned MaxFrame   = 1024;
  localparam int unsigned QueueDepth = 4;

  localparam logic [7:0]  ChEnd    = 8'hC0;
  localparam logic [7:0]  ChEsc    = 8'hDB;
  localparam logic [7:0]  ChEscEnd = 8'hDC;
  localparam logic [7:0]  ChEscEsc = 8'hDD;

  localparam logic [16:0] ElapsedMax  = 17'h1FFFF;
  localparam logic [10:0] MaxLenReset = 11'd1024;
  localparam logic [15:0] WaitMsReset = 16'd1000;

  typedef enum logic [2:0] {
    KIND_DATA     = 3'd0,
    KIND_END      = 3'd1,
    KIND_FRAMING  = 3'd2,
    KIND_BUFSHORT = 3'd3,
    KIND_TIMEOUT  = 3'd4
  } kind_e;

  typedef enum logic {
    REG_MAX_LEN = 1'b0,
    REG_WAIT_MS = 1'b1
  } reg_idx_e;

  typedef enum logic {
    FUNC_BYTE = 1'b0,
    FUNC_TICK = 1'b1
  } func_e;

  typedef struct packed {
    logic        two;
    kind_e       kind;
    logic [7:0]  data;
    logic [10:0] len;
  } sfd_entry_t;

endpackage

>>> hdl/sfd_front.sv
module sfd_front import sfd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic        func_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  output logic        push_o,
  output sfd_entry_t  entry_o
);

  logic [10:0] max_len_q, max_len_d;
  logic [15:0] wait_ms_q, wait_ms_d;
  logic        esc_q, esc_d;
  logic [10:0] count_q, count_d;
  logic [16:0] elapsed_q, elapsed_d;

  logic [10:0] limit;
  logic [10:0] cnt_inc;
  logic [16:0] el_inc;
  logic        store;
  logic [7:0]  store_byte;

  assign limit   = (max_len_q < MaxFrame[10:0]) ? max_len_q : MaxFrame[10:0];
  assign cnt_inc = count_q + 11'd1;
  assign el_inc  = (elapsed_q != ElapsedMax) ? elapsed_q + 17'd1 : elapsed_q;

  always_comb begin
    max_len_d = max_len_q;
    wait_ms_d = wait_ms_q;
    if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_MAX_LEN: max_len_d = cfg_wdata_i[10:0];
        REG_WAIT_MS: wait_ms_d = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    esc_d      = esc_q;
    count_d    = count_q;
    elapsed_d  = elapsed_q;
    push_o     = 1'b0;
    entry_o    = '0;
    store      = 1'b0;
    store_byte = rx_byte_i;
    if (accept_i) begin
      if (func_e'(func_i) == FUNC_TICK) begin
        if (el_inc > {1'b0, wait_ms_q}) begin
          push_o       = 1'b1;
          entry_o.kind = KIND_TIMEOUT;
          esc_d        = 1'b0;
          count_d      = '0;
          elapsed_d    = '0;
        end else begin
          elapsed_d = el_inc;
        end
      end else if (esc_q) begin
        esc_d = 1'b0;
        if (rx_byte_i == ChEscEnd) begin
          store      = 1'b1;
          store_byte = ChEnd;
        end else if (rx_byte_i == ChEscEsc) begin
          store      = 1'b1;
          store_byte = ChEsc;
        end else begin
          push_o       = 1'b1;
          entry_o.kind = KIND_FRAMING;
          count_d      = '0;
          elapsed_d    = '0;
        end
      end else if (rx_byte_i == ChEnd) begin
        if (count_q != '0) begin
          push_o       = 1'b1;
          entry_o.kind = KIND_END;
          entry_o.len  = count_q;
          count_d      = '0;
          elapsed_d    = '0;
        end
      end else if (rx_byte_i == ChEsc) begin
        esc_d = 1'b1;
      end else begin
        store = 1'b1;
      end

      if (store) begin
        push_o       = 1'b1;
        entry_o.kind = KIND_DATA;
        entry_o.data = store_byte;
        if (cnt_inc >= limit) begin
          entry_o.two = 1'b1;
          esc_d       = 1'b0;
          count_d     = '0;
          elapsed_d   = '0;
        end else begin
          count_d = cnt_inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxLenReset;
      wait_ms_q <= WaitMsReset;
      esc_q     <= 1'b0;
      count_q   <= '0;
      elapsed_q <= '0;
    end else begin
      max_len_q <= max_len_d;
      wait_ms_q <= wait_ms_d;
      esc_q     <= esc_d;
      count_q   <= count_d;
      elapsed_q <= elapsed_d;
    end
  end

endmodule

>>> hdl/sfd_queue.sv
module sfd_queue import sfd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  sfd_entry_t entry_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       empty_o,
  output sfd_entry_t entry_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  sfd_entry_t mem_q [QueueDepth];

  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push;
  logic            do_pop;

  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign entry_o = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(QueueDepth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

>>> hdl/sfd_back.sv
module sfd_back import sfd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_empty_i,
  input  sfd_entry_t  q_entry_i,
  output logic        q_pop_o,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  kind_o,
  output logic [7:0]  payload_byte_o,
  output logic [10:0] frame_length_o,
  output logic        last_o
);

  logic        vld_q, vld_d;
  logic        pend_q, pend_d;
  kind_e       kind_q, kind_d;
  logic [7:0]  byte_q, byte_d;
  logic [10:0] len_q, len_d;
  logic        last_q, last_d;
  logic        take;

  assign take = !vld_q || pop;

  always_comb begin
    vld_d   = vld_q;
    pend_d  = pend_q;
    kind_d  = kind_q;
    byte_d  = byte_q;
    len_d   = len_q;
    last_d  = last_q;
    q_pop_o = 1'b0;
    if (take) begin
      if (pend_q) begin
        vld_d  = 1'b1;
        pend_d = 1'b0;
        kind_d = KIND_BUFSHORT;
        byte_d = '0;
        len_d  = '0;
        last_d = 1'b1;
      end else if (!q_empty_i) begin
        q_pop_o = 1'b1;
        vld_d   = 1'b1;
        pend_d  = q_entry_i.two;
        kind_d  = q_entry_i.kind;
        byte_d  = q_entry_i.data;
        len_d   = q_entry_i.len;
        last_d  = !q_entry_i.two;
      end else begin
        vld_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      pend_q <= 1'b0;
    end else begin
      vld_q  <= vld_d;
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    byte_q <= byte_d;
    len_q  <= len_d;
    last_q <= last_d;
  end

  assign empty          = !vld_q;
  assign kind_o         = kind_q;
  assign payload_byte_o = byte_q;
  assign frame_length_o = len_q;
  assign last_o         = last_q;

endmodule

>>> hdl/slip_frame_decoder_core.sv
// SLIP receive deframer with a per-frame millisecond timer.
// Input channel: push/full. Each transaction is either a received byte
// (func_i = 0, rx_byte_i) or a one-millisecond tick (func_i = 1). One
// transaction is taken per cycle while full is low.
// Result channel: empty/pop. Each result carries kind_o (data, frame end,
// framing error, buffer short, timeout), payload_byte_o, frame_length_o and
// last_o, which marks the final result of an input transaction. A stored
// byte that reaches the length limit yields two results, data then buffer
// short. A result passes the queue and the output register before it is
// visible. Throughput: one input per cycle while full is low, one result per
// cycle while pop is high; a four-entry queue between the decoder and the
// output register absorbs bursts and raises full only while it is filled.
// Configuration: cfg_we_i writes cfg_wdata_i into max_len (index 0) or
// wait_ms (index 1); write only while the block is idle.
// Reset clears frame state, the queue and the output, and restores
// max_len to 1024 and wait_ms to 1000. When the receiver stalls, the
// current result holds and the queue fills, then full rises.
module slip_frame_decoder_core import sfd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        func_i,
  input  logic [7:0]  rx_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  kind_o,
  output logic [7:0]  payload_byte_o,
  output logic [10:0] frame_length_o,
  output logic        last_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);

  logic       accept;
  logic       f_push;
  sfd_entry_t f_entry;
  logic       q_empty;
  logic       q_pop;
  sfd_entry_t q_entry;

  assign accept = push && !full;

  sfd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .func_i      (func_i),
    .rx_byte_i   (rx_byte_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push_o      (f_push),
    .entry_o     (f_entry)
  );

  sfd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .entry_i (f_entry),
    .full_o  (full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .entry_o (q_entry)
  );

  sfd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .q_entry_i      (q_entry),
    .q_pop_o        (q_pop),
    .empty          (empty),
    .pop            (pop),
    .kind_o         (kind_o),
    .payload_byte_o (payload_byte_o),
    .frame_length_o (frame_length_o),
    .last_o         (last_o)
  );

endmodule

>>> bench/tb_slip_frame_decoder_core.sv
module tb_slip_frame_decoder_core;
  import sfd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int Limit   = 400000;
  localparam int Settle  = 8;
  localparam int Predict = -1;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  payload;
    logic [10:0] length;
    logic        last;
  } result_t;

  typedef enum logic {
    OP_ITEM = 1'b0,
    OP_CFG  = 1'b1
  } row_op_e;

  typedef struct {
    row_op_e     op;
    reg_idx_e    idx;
    logic [15:0] val;
    func_e       func;
    logic [7:0]  rx;
    int          n_typed;
    kind_e       k0;
    logic [7:0]  b0;
    logic [10:0] l0;
    kind_e       k1;
  } row_t;

  typedef struct {
    logic [15:0] max_len;
    logic [15:0] wait_ms;
    int          items;
    int          long_len;
    logic        steady;
  } phase_t;

  logic        clk         = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        push        = 1'b0;
  logic        full;
  logic        func_i      = 1'b0;
  logic [7:0]  rx_byte_i   = 8'h00;
  logic        empty;
  logic        pop         = 1'b0;
  logic [2:0]  kind_o;
  logic [7:0]  payload_byte_o;
  logic [10:0] frame_length_o;
  logic        last_o;
  logic        cfg_we_i    = 1'b0;
  logic        cfg_idx_i   = REG_MAX_LEN;
  logic [15:0] cfg_wdata_i = 16'h0000;

  slip_frame_decoder_core u_top (
    .clk_i          (clk),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .func_i         (func_i),
    .rx_byte_i      (rx_byte_i),
    .empty          (empty),
    .pop            (pop),
    .kind_o         (kind_o),
    .payload_byte_o (payload_byte_o),
    .frame_length_o (frame_length_o),
    .last_o         (last_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always #1 clk = ~clk;

  result_t     decoded_q [$];
  int          mismatches  = 0;
  int          cycle_count = 0;
  int          sent        = 0;
  logic        steady_tx   = 1'b0;
  logic        steady_rx   = 1'b0;

  logic [10:0] max_len_r   = MaxLenReset;
  logic [15:0] wait_ms_r   = WaitMsReset;
  logic        esc_seen    = 1'b0;
  logic [10:0] frame_len   = '0;
  logic [16:0] frame_ms    = '0;

  function automatic result_t make_result(kind_e k, logic [7:0] b, logic [10:0] l, logic last);
    result_t r;
    r.kind    = k;
    r.payload = b;
    r.length  = l;
    r.last    = last;
    return r;
  endfunction

  function automatic void clear_frame();
    esc_seen  = 1'b0;
    frame_len = '0;
    frame_ms  = '0;
  endfunction

  function automatic int deframe(input func_e f, input logic [7:0] b, output result_t res [2]);
    logic        store_it = 1'b0;
    logic [7:0]  value    = b;
    logic [10:0] limit;
    int          n        = 0;
    res[0] = '0;
    res[1] = '0;
    if (f == FUNC_TICK) begin
      if (frame_ms < ElapsedMax) frame_ms = frame_ms + 1'b1;
      if (frame_ms > {1'b0, wait_ms_r}) begin
        res[0] = make_result(KIND_TIMEOUT, '0, '0, 1'b1);
        clear_frame();
        n = 1;
      end
    end else if (esc_seen) begin
      esc_seen = 1'b0;
      if (b == ChEscEnd) begin
        store_it = 1'b1;
        value    = ChEnd;
      end else if (b == ChEscEsc) begin
        store_it = 1'b1;
        value    = ChEsc;
      end else begin
        res[0] = make_result(KIND_FRAMING, '0, '0, 1'b1);
        clear_frame();
        n = 1;
      end
    end else if (b == ChEnd) begin
      if (frame_len != 0) begin
        res[0] = make_result(KIND_END, '0, frame_len, 1'b1);
        clear_frame();
        n = 1;
      end
    end else if (b == ChEsc) begin
      esc_seen = 1'b1;
    end else begin
      store_it = 1'b1;
    end
    if (store_it) begin
      limit     = (max_len_r < MaxFrame) ? max_len_r : 11'(MaxFrame);
      frame_len = frame_len + 1'b1;
      if (frame_len >= limit) begin
        res[0] = make_result(KIND_DATA, value, '0, 1'b0);
        res[1] = make_result(KIND_BUFSHORT, '0, '0, 1'b1);
        clear_frame();
        n = 2;
      end else begin
        res[0] = make_result(KIND_DATA, value, '0, 1'b1);
        n = 1;
      end
    end
    return n;
  endfunction

  task automatic note_mismatch(string what, result_t want, result_t got);
    if (mismatches < 10)
      $display({"%s: expected kind %0d byte %02h len %0d last %0b,",
                " got kind %0d byte %02h len %0d last %0b"},
               what, want.kind, want.payload, want.length, want.last,
               got.kind, got.payload, got.length, got.last);
    mismatches++;
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_ni && pop && !empty) begin
      got = make_result(kind_e'(kind_o), payload_byte_o, frame_length_o, last_o);
      if (decoded_q.size() == 0) begin
        note_mismatch("unexpected result", '0, got);
      end else begin
        want = decoded_q.pop_front();
        if (got.kind !== want.kind || got.payload !== want.payload ||
            got.length !== want.length || got.last !== want.last)
          note_mismatch("result mismatch", want, got);
      end
    end
    pop <= rst_ni && (steady_rx || $urandom_range(0, 99) >= 31);
  end

  // drop the input and hold until the block has drained
  task automatic quiesce();
    push <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (Settle) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [15:0] val);
    quiesce();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk);
    if (idx == REG_MAX_LEN) max_len_r = val[10:0];
    else wait_ms_r = val;
    cfg_we_i <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_item(input func_e f, input logic [7:0] b, output int n,
                           output result_t res [2]);
    while (!steady_tx && $urandom_range(0, 99) < 31) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push      <= 1'b1;
    func_i    <= f;
    rx_byte_i <= b;
    do @(posedge clk); while (full);
    n = deframe(f, b, res);
    sent++;
  endtask

  task automatic send_checked(func_e f, logic [7:0] b);
    int      n;
    result_t res [2];
    send_item(f, b, n, res);
    for (int i = 0; i < n; i++) decoded_q.push_back(res[i]);
  endtask

  task automatic send_frame(int len);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 9))
        0:       b = ChEnd;
        1:       b = ChEsc;
        default: b = 8'($urandom_range(0, 255));
      endcase
      if (b == ChEnd) begin
        send_checked(FUNC_BYTE, ChEsc);
        send_checked(FUNC_BYTE, ChEscEnd);
      end else if (b == ChEsc) begin
        send_checked(FUNC_BYTE, ChEsc);
        send_checked(FUNC_BYTE, ChEscEsc);
      end else begin
        send_checked(FUNC_BYTE, b);
      end
      if ($urandom_range(0, 99) < 8) send_checked(FUNC_TICK, 8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 99) < 90) send_checked(FUNC_BYTE, ChEnd);
  endtask

  task automatic send_noise();
    case ($urandom_range(0, 2))
      0: send_checked(FUNC_BYTE, 8'($urandom_range(0, 255)));
      1: begin
        send_checked(FUNC_BYTE, ChEsc);
        send_checked(FUNC_BYTE, 8'($urandom_range(0, 255)));
      end
      default: begin
        send_checked(FUNC_BYTE, ChEsc);
        send_checked(FUNC_BYTE, ChEnd);
      end
    endcase
  endtask

  row_t dir_rows [29] = '{
    '{OP_ITEM, REG_MAX_LEN, 16'd0, FUNC_BYTE, 8'hC0, 0, KIND_DATA, 8'h00, 11'd0, KIND_DATA},
    '{OP_ITEM, REG_MAX_LEN, 16'd0, FUNC_BYTE, 8'h00, 1, KIND_DATA, 8'h00, 11'd0, KIND_DATA},
    '{OP_ITEM, REG_MAX_LEN, 16'd0, FUNC_BYTE, 8'hFF, 1, KIND_DATA, 8'hFF, 11'd0, KIND_DATA},
    '{OP_ITEM, REG_MAX_LEN, 16'd0, FUNC_BYTE, 8'hDB, 0, KIND_DATA, 8'h00, 11'd0, KIND_DATA},
    '{OP_ITEM, REG_MAX_LEN, 16'd0, FUNC_BYTE, 8'hDC, 1, KIND_DATA, 8'hC0, 11'd0, KIND_DATA},
    '{OP_ITEM, REG_MAX_LEN, 16'd0, FUNC_BYTE, 8'hDB, 0, KIND_DATA, 8'h00, 11'd0, KIND_DATA},
    '{OP_ITEM, REG_MAX_LEN, 16'd0, FUNC_BYTE, 8'hDD, 1, KIND_DATA, 8'hDB, 11'd0, KIND_DATA},
    '{OP_ITEM, REG_MAX_LEN, 16'd0, FUNC_BYTE, 8'hC0, 1, KIND_END, 8'h00, 11'd4, KIND_DATA},
    '{OP_ITEM, REG_MAX_LEN, 16'd0, FUNC_BYTE, 8'hDB, 0, KIND_DATA, 8'h00, 11'd0, KIND_DATA},
    '{OP_ITEM, REG_MAX_LEN, 16'd0, FUNC_BYTE, 8'hC0, 1, KIND_FRAMING, 8'h00, 11'd0, KIND_DATA},
    '{OP_ITEM, REG_MAX_LEN, 16'd0, FUNC_BYTE, 8'hDB, 0, KIND_DATA, 8'h00, 11'd0, KIND_DATA},
    '{OP_ITEM, REG_MAX_LEN, 16'd0, FUNC_BYTE, 8'h41, 1, KIND_FRAMING, 8'h00, 11'd0, KIND_DATA},
    '{OP_ITEM, REG_MAX_LEN, 16'd0, FUNC_TICK, 8'h00, 0, KIND_DATA, 8'h00, 11'd0, KIND_DATA},
    '{OP_ITEM, REG_MAX_LEN, 16'd0, FUNC_BYTE, 8'h5A, Predict, KIND_DATA, 8'h00, 11'd0, KIND_DATA},
    '{OP_ITEM, REG_MAX_LEN, 16'd0, FUNC_BYTE, 8'hA5, Predict, KIND_DATA, 8'h00, 11'd0, KIND_DATA},
    '{OP_CFG, REG_MAX_LEN, 16'd2, FUNC_BYTE, 8'h00, 0, KIND_DATA, 8'h00, 11'd0, KIND_DATA},
    '{OP_ITEM, REG_MAX_LEN, 16'd0, FUNC_BYTE, 8'h3C, 2, KIND_DATA, 8'h3C, 11'd0, KIND_BUFSHORT},
    '{OP_CFG, REG_WAIT_MS, 16'd0, FUNC_BYTE, 8'h00, 0, KIND_DATA, 8'h00, 11'd0, KIND_DATA},
    '{OP_ITEM, REG_MAX_LEN, 16'd0, FUNC_TICK, 8'hFF, 1, KIND_TIMEOUT, 8'h00, 11'd0, KIND_DATA},
    '{OP_CFG, REG_MAX_LEN, 16'd0, FUNC_BYTE, 8'h00, 0, KIND_DATA, 8'h00, 11'd0, KIND_DATA},
    '{OP_ITEM, REG_MAX_LEN, 16'd0, FUNC_BYTE, 8'h7E, 2, KIND_DATA, 8'h7E, 11'd0, KIND_BUFSHORT},
    '{OP_CFG, REG_MAX_LEN, 16'd2047, FUNC_BYTE, 8'h00, 0, KIND_DATA, 8'h00, 11'd0, KIND_DATA},
    '{OP_CFG, REG_WAIT_MS, 16'd1, FUNC_BYTE, 8'h00, 0, KIND_DATA, 8'h00, 11'd0, KIND_DATA},
    '{OP_ITEM, REG_MAX_LEN, 16'd0, FUNC_TICK, 8'h00, 0, KIND_DATA, 8'h00, 11'd0, KIND_DATA},
    '{OP_ITEM, REG_MAX_LEN, 16'd0, FUNC_BYTE, 8'h11, Predict, KIND_DATA, 8'h00, 11'd0, KIND_DATA},
    '{OP_ITEM, REG_MAX_LEN, 16'd0, FUNC_TICK, 8'h00, 1, KIND_TIMEOUT, 8'h00, 11'd0, KIND_DATA},
    '{OP_ITEM, REG_MAX_LEN, 16'd0, FUNC_BYTE, 8'hC0, 0, KIND_DATA, 8'h00, 11'd0, KIND_DATA},
    '{OP_ITEM, REG_MAX_LEN, 16'd0, FUNC_BYTE, 8'h80, Predict, KIND_DATA, 8'h00, 11'd0, KIND_DATA},
    '{OP_ITEM, REG_MAX_LEN, 16'd0, FUNC_BYTE, 8'hC0, 1, KIND_END, 8'h00, 11'd1, KIND_DATA}
  };

  phase_t phases [9] = '{
    '{16'd1024, 16'd1000, 120, 0, 1'b0},
    '{16'd1, 16'd5, 90, 0, 1'b0},
    '{16'd2, 16'd0, 70, 0, 1'b0},
    '{16'd7, 16'd30, 130, 0, 1'b1},
    '{16'd0, 16'd12, 60, 0, 1'b0},
    '{16'd2047, 16'd65535, 40, 0, 1'b0},
    '{16'd300, 16'd200, 130, 0, 1'b0},
    '{16'd16, 16'd65535, 100, 0, 1'b0},
    '{16'd1024, 16'd40, 120, 0, 1'b0}
  };

  initial begin
    while (cycle_count < Limit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int      n;
    int      start;
    int      r;
    logic    drained;
    result_t res [2];
    repeat (9) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].op == OP_CFG) begin
        write_reg(dir_rows[i].idx, dir_rows[i].val);
      end else begin
        send_item(dir_rows[i].func, dir_rows[i].rx, n, res);
        if (dir_rows[i].n_typed == Predict) begin
          for (int k = 0; k < n; k++) decoded_q.push_back(res[k]);
        end else begin
          if (dir_rows[i].n_typed >= 1)
            decoded_q.push_back(make_result(dir_rows[i].k0, dir_rows[i].b0, dir_rows[i].l0,
                                            dir_rows[i].n_typed == 1));
          if (dir_rows[i].n_typed == 2)
            decoded_q.push_back(make_result(dir_rows[i].k1, '0, '0, 1'b1));
        end
      end
    end

    foreach (phases[p]) begin
      write_reg(REG_MAX_LEN, phases[p].max_len);
      write_reg(REG_WAIT_MS, phases[p].wait_ms);
      steady_tx = phases[p].steady;
      steady_rx <= phases[p].steady;
      if (phases[p].long_len > 0) send_frame(phases[p].long_len);
      start   = sent;
      drained = 1'b0;
      while (sent - start < phases[p].items) begin
        if (!drained && sent - start >= phases[p].items / 2) begin
          quiesce();
          drained = 1'b1;
        end
        r = $urandom_range(0, 99);
        if (r < 70)
          send_frame($urandom_range(0, 99) < 90 ? $urandom_range(0, 12)
                                                : $urandom_range(13, 80));
        else if (r < 85)
          repeat ($urandom_range(1, 8)) send_checked(FUNC_TICK, 8'($urandom_range(0, 255)));
        else
          send_noise();
      end
    end

    quiesce();
    if (mismatches == 0 && decoded_q.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
